>>> rtl/whl_pkg.sv
// ---------------------------------------------------------------------------
// whl_pkg
// Shared field widths, operation and status codes, and item types for the
// ID whitelist table.
// ---------------------------------------------------------------------------
package whl_pkg;

    localparam int OP_W     = 3;
    localparam int ID_W     = 32;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd1;
    localparam logic [OP_W-1:0] OP_READ   = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [ID_W-1:0]  card_id;
        logic [POS_W-1:0] position;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    entry_count;
        logic [POS_W-1:0]    match_position;
        logic [ID_W-1:0]     read_id;
    } rsp_item_t;

endpackage

>>> rtl/whl_stream_if.sv
// ---------------------------------------------------------------------------
// whl_stream_if
// Valid/ready channel carrying one item of type T per handshake.
// ---------------------------------------------------------------------------
interface whl_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/whl_cell.sv
// ---------------------------------------------------------------------------
// whl_cell
// One storage cell of the ID ring; takes its neighbor's ID when the ring
// rotates and holds otherwise.
// ---------------------------------------------------------------------------
module whl_cell
    import whl_pkg::*;
(
    input  logic            clk,
    input  logic            shift,
    input  logic [ID_W-1:0] d,
    output logic [ID_W-1:0] q
);

    logic [ID_W-1:0] id_reg;
    logic [ID_W-1:0] id_next;

    always_comb
    begin
        id_next = shift ? d : id_reg;
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign q = id_reg;

endmodule

>>> rtl/id_whitelist_table_core.sv
// ---------------------------------------------------------------------------
// id_whitelist_table_core
// Ordered table of card IDs held in a ring of cells that rotates once per
// item; every operation is resolved at the head cell during the walk.
// ---------------------------------------------------------------------------
// An item is accepted only while idle, and the next one waits until the walk
// ends: one full rotation of the cell ring walks every entry past the head
// comparator, stalling at its last step while the previous result is unread.
// Reset clears the entry count and all control state; cell contents stay
// undefined until written and are never read before that.
module id_whitelist_table_core
    import whl_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    whl_stream_if.sink   req,
    whl_stream_if.source rsp
);

    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int NEXT_IDX = (CAPACITY > 1) ? 1 : 0;
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(CAPACITY - 1);
    localparam logic [CMP_W-1:0] CAP_CMP   = CMP_W'(CAPACITY);

    typedef enum logic {S_IDLE, S_WALK} state_t;

    state_t            state_reg,     state_next;
    logic [IDX_W-1:0]  step_reg,      step_next;
    logic [CNT_W-1:0]  cnt_reg,       cnt_next;
    logic [OP_W-1:0]   op_reg,        op_next;
    logic [ID_W-1:0]   id_reg,        id_next;
    logic [POS_W-1:0]  pos_reg,       pos_next;
    logic              pos_bad_reg,   pos_bad_next;
    logic              found_reg,     found_next;
    logic [CNT_W-1:0]  match_reg,     match_next;
    logic [ID_W-1:0]   rid_reg,       rid_next;
    rsp_item_t         out_reg,       out_next;
    logic              out_valid_reg, out_valid_next;

    logic [ID_W-1:0]  cell_q [CAPACITY];
    logic [ID_W-1:0]  tail_d;
    logic             shift;
    logic             last;
    logic [CMP_W-1:0] step_c;
    logic [CMP_W-1:0] cnt_c;
    logic [CMP_W-1:0] pos_c;
    logic             hit;
    logic             add_write;
    logic             del_shift;
    logic             rd_hit;
    logic             found_fin;
    logic [CNT_W-1:0] match_fin;
    logic [ID_W-1:0]  rid_fin;

    // Ring of cells: cell 0 is the head, the tail takes the fed-back value.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == CAPACITY - 1)
        begin : g_tail
            whl_cell u_cell (.clk(clk), .shift(shift), .d(tail_d), .q(cell_q[i]));
        end
        else
        begin : g_body
            whl_cell u_cell (.clk(clk), .shift(shift), .d(cell_q[i+1]), .q(cell_q[i]));
        end
    end

    assign step_c = CMP_W'(step_reg);
    assign cnt_c  = CMP_W'(cnt_reg);
    assign pos_c  = CMP_W'(pos_reg);
    assign last   = (step_reg == LAST_STEP);
    assign shift  = (state_reg == S_WALK) && !(last && out_valid_reg && !rsp.ready);

    // At step k the head holds entry k, and the value fed to the tail lands
    // in entry k once the rotation is complete.
    assign hit       = (step_c < cnt_c) && (cell_q[0] == id_reg) && !found_reg;
    assign add_write = (op_reg == OP_ADD) && (step_c == cnt_c) && !found_reg;
    assign del_shift = (op_reg == OP_DELETE) && !pos_bad_reg
                       && ((step_c + CMP_W'(1)) >= pos_c);
    assign rd_hit    = (op_reg == OP_READ) && !pos_bad_reg
                       && ((step_c + CMP_W'(1)) == pos_c);

    always_comb
    begin
        if (add_write)
            tail_d = id_reg;
        else if (del_shift)
            tail_d = cell_q[NEXT_IDX];
        else
            tail_d = cell_q[0];
    end

    assign found_fin = found_reg || hit;
    assign match_fin = hit ? (CNT_W'(step_reg) + CNT_W'(1)) : match_reg;
    assign rid_fin   = rd_hit ? cell_q[0] : rid_reg;

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        pos_next       = pos_reg;
        pos_bad_next   = pos_bad_reg;
        found_next     = found_reg;
        match_next     = match_reg;
        rid_next       = rid_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (rsp.valid && rsp.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next   = S_WALK;
                    step_next    = '0;
                    op_next      = req.data.opcode;
                    id_next      = req.data.card_id;
                    pos_next     = req.data.position;
                    pos_bad_next = (req.data.position == '0)
                                   || (CMP_W'(req.data.position) > cnt_c);
                    found_next   = 1'b0;
                    match_next   = '0;
                    rid_next     = '0;
                end
            end
            S_WALK:
            begin
                if (shift)
                begin
                    found_next = found_fin;
                    match_next = match_fin;
                    rid_next   = rid_fin;
                    step_next  = step_reg + IDX_W'(1);
                    if (last)
                    begin
                        state_next               = S_IDLE;
                        step_next                = '0;
                        out_valid_next           = 1'b1;
                        out_next.status          = ST_OK;
                        out_next.match_position  = '0;
                        out_next.read_id         = '0;
                        case (op_reg)
                            OP_ADD:
                            begin
                                if (found_fin)
                                    out_next.status = ST_DUP;
                                else if (cnt_c >= CAP_CMP)
                                    out_next.status = ST_FULL;
                                else
                                    cnt_next = cnt_reg + CNT_W'(1);
                            end
                            OP_LOOKUP:
                            begin
                                out_next.match_position = POS_W'(match_fin);
                            end
                            OP_READ:
                            begin
                                if (pos_bad_reg)
                                    out_next.status = ST_BADPOS;
                                else
                                    out_next.read_id = rid_fin;
                            end
                            OP_DELETE:
                            begin
                                if (pos_bad_reg)
                                    out_next.status = ST_BADPOS;
                                else
                                    cnt_next = cnt_reg - CNT_W'(1);
                            end
                            OP_CLEAR:
                            begin
                                cnt_next = '0;
                            end
                            default:
                            begin
                                cnt_next = cnt_reg;
                            end
                        endcase
                        out_next.entry_count = POS_W'(cnt_next);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            cnt_reg       <= '0;
            op_reg        <= '0;
            id_reg        <= '0;
            pos_reg       <= '0;
            pos_bad_reg   <= 1'b0;
            found_reg     <= 1'b0;
            match_reg     <= '0;
            rid_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            op_reg        <= op_next;
            id_reg        <= id_next;
            pos_reg       <= pos_next;
            pos_bad_reg   <= pos_bad_next;
            found_reg     <= found_next;
            match_reg     <= match_next;
            rid_reg       <= rid_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The entry count never passes the table size.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(cnt_reg) <= CAP_CMP)
        else $error("entry count above capacity");

    // The step counter rests at zero whenever no walk is in progress.
    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (step_reg == '0))
        else $error("step counter moved outside a walk");

    // A new result only appears at the end of a walk.
    a_rsp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_WALK) && $past(last))
        else $error("result raised outside the last walk step");

    // A duplicate add reports no match position and no read data.
    a_dup_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status == ST_DUP))
        |-> (out_reg.match_position == '0) && (out_reg.read_id == '0))
        else $error("duplicate status with stray payload");

    // The ring stays still while the walk waits for the result to drain.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_WALK) && last && out_valid_reg && !rsp.ready)
        |=> (state_reg == S_WALK) && last)
        else $error("walk finished while the result slot was busy");

endmodule
